// ===== rtl/c8ie_pkg.sv =====
`default_nettype none
package c8ie_pkg;

    localparam int unsigned MEM_BYTES_DEF = 4096;
    localparam int unsigned STACK_DEF     = 16;
    localparam logic [11:0] PC_RESET      = 12'd512;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_REG   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_UNK   = 2'd3;

    localparam logic [15:0] OPC_RET = 16'h00EE;

    typedef struct packed {
        logic [7:0]  random_byte;
        logic [7:0]  write_data;
        logic [11:0] address;
        logic [1:0]  operation;
    } c8ie_item_t;

    typedef struct packed {
        logic [7:0]  sound_out;
        logic [7:0]  delay_out;
        logic [1:0]  status;
        logic [15:0] opcode_out;
        logic [15:0] index_out;
        logic [11:0] program_counter_out;
        logic [7:0]  read_data;
    } c8ie_result_t;

    // reduce a 16-bit address modulo the memory size, m >= 512
    function automatic logic [15:0] mem_wrap(input logic [15:0] a, input int unsigned m);
        logic [31:0] r;
        r = {16'd0, a};
        for (int k = 6; k >= 0; k--)
        begin
            if (r >= (m << k))
            begin
                r = r - (m << k);
            end
        end
        return r[15:0];
    endfunction

    // decimal digit of v: 0 hundreds, 1 tens, 2 ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [7:0]  h;
        logic [7:0]  r;
        logic [15:0] p;
        logic [7:0]  t;
        logic [7:0]  o;
        if (v >= 8'd200)
        begin
            h = 8'd2;
            r = v - 8'd200;
        end
        else if (v >= 8'd100)
        begin
            h = 8'd1;
            r = v - 8'd100;
        end
        else
        begin
            h = 8'd0;
            r = v;
        end
        p = {8'd0, r} * 16'd205;
        t = {3'd0, p[15:11]};
        o = r - t * 8'd10;
        if (sel == 2'd0)
        begin
            return h;
        end
        else if (sel == 2'd1)
        begin
            return t;
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/c8ie_front.sv =====
`default_nettype none
module c8ie_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire c8ie_pkg::c8ie_item_t in_item,
    output logic                    q_valid,
    output c8ie_pkg::c8ie_item_t    q_item,
    input  wire logic               q_pop
);
    import c8ie_pkg::*;

    c8ie_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/c8ie_exec.sv =====
`default_nettype none
module c8ie_exec #(
    parameter int unsigned MEMORY_BYTES  = c8ie_pkg::MEM_BYTES_DEF,
    parameter int unsigned STACK_ENTRIES = c8ie_pkg::STACK_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire c8ie_pkg::c8ie_item_t q_item,
    output logic                      q_pop,
    input  wire logic                 cfg_we,
    input  wire logic [11:0]          cfg_pc,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output c8ie_pkg::c8ie_result_t    res
);
    import c8ie_pkg::*;

    localparam int unsigned AW = $clog2(MEMORY_BYTES);
    localparam int unsigned SW = $clog2(STACK_ENTRIES);
    localparam int unsigned DW = $clog2(STACK_ENTRIES + 1);

    typedef enum logic [16:0] {
        S_IDLE = 17'h00001,
        S_MRD  = 17'h00002,
        S_RREG = 17'h00004,
        S_CAP  = 17'h00008,
        S_F0   = 17'h00010,
        S_F1   = 17'h00020,
        S_F2   = 17'h00040,
        S_RY   = 17'h00080,
        S_EXEC = 17'h00100,
        S_FLAG = 17'h00200,
        S_RET  = 17'h00400,
        S_BCD  = 17'h00800,
        S_STR  = 17'h01000,
        S_STW  = 17'h02000,
        S_LDR  = 17'h04000,
        S_LDW  = 17'h08000,
        S_DONE = 17'h10000
    } state_t;

    state_t       state_reg, state_next;
    logic [11:0]  pc_reg, pc_next;
    logic [15:0]  idx_reg, idx_next;
    logic [7:0]   dly_reg, dly_next;
    logic [7:0]   snd_reg, snd_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [15:0]  op_reg, op_next;
    c8ie_item_t   item_reg, item_next;
    logic [7:0]   rd_reg, rd_next;
    logic [1:0]   st_reg, st_next;
    logic [7:0]   va_reg, va_next;
    logic         flag_reg, flag_next;
    logic [3:0]   i_reg, i_next;
    logic [1:0]   cnt_reg, cnt_next;
    c8ie_result_t res_reg, res_next;
    logic         res_valid_reg, res_valid_next;

    logic [7:0]   mem [MEMORY_BYTES];
    logic [7:0]   mem_q_reg;
    logic         mem_we;
    logic [15:0]  mem_wa16;
    logic [7:0]   mem_wd;
    logic [15:0]  mem_ra16;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    logic [7:0]   vfile [16];
    logic [15:0]  vvalid_reg;
    logic [7:0]   vq_reg;
    logic         v_we;
    logic [3:0]   v_wa;
    logic [7:0]   v_wd;
    logic [3:0]   v_ra;

    logic [11:0]  stack [STACK_ENTRIES];
    logic [11:0]  stack_q_reg;
    logic         stk_we;
    logic [DW-1:0] depth_m1;

    logic [3:0]   x;
    logic [3:0]   y;
    logic [3:0]   n;
    logic [7:0]   nn;
    logic [11:0]  nnn;
    logic [11:0]  pc2;
    logic [11:0]  pc4;
    logic [8:0]   sum9;

    assign x     = op_reg[11:8];
    assign y     = op_reg[7:4];
    assign n     = op_reg[3:0];
    assign nn    = op_reg[7:0];
    assign nnn   = op_reg[11:0];
    assign pc2   = pc_reg + 12'd2;
    assign pc4   = pc_reg + 12'd4;
    assign sum9  = {1'b0, va_reg} + {1'b0, vq_reg};
    assign depth_m1 = depth_reg - 1'b1;

    assign mem_waddr = AW'(mem_wrap(mem_wa16, MEMORY_BYTES));
    assign mem_raddr = AW'(mem_wrap(mem_ra16, MEMORY_BYTES));

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        idx_next       = idx_reg;
        dly_next       = dly_reg;
        snd_next       = snd_reg;
        depth_next     = depth_reg;
        op_next        = op_reg;
        item_next      = item_reg;
        rd_next        = rd_reg;
        st_next        = st_reg;
        va_next        = va_reg;
        flag_next      = flag_reg;
        i_next         = i_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res_ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa16       = idx_reg;
        mem_wd         = vq_reg;
        mem_ra16       = {4'd0, pc_reg};
        v_we           = 1'b0;
        v_wa           = x;
        v_wd           = 8'd0;
        v_ra           = x;
        stk_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    rd_next   = 8'd0;
                    st_next   = ST_OK;
                    op_next   = 16'd0;
                    unique case (q_item.operation)
                        OP_WRITE:
                        begin
                            mem_we     = 1'b1;
                            mem_wa16   = {4'd0, q_item.address};
                            mem_wd     = q_item.write_data;
                            state_next = S_DONE;
                        end
                        OP_EXEC: state_next = S_F0;
                        OP_READ: state_next = S_MRD;
                        OP_REG:  state_next = S_RREG;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_MRD:
            begin
                mem_ra16   = {4'd0, item_reg.address};
                state_next = S_CAP;
            end
            S_RREG:
            begin
                v_ra       = item_reg.address[3:0];
                state_next = S_CAP;
            end
            S_CAP:
            begin
                rd_next    = (item_reg.operation == OP_READ) ? mem_q_reg : vq_reg;
                state_next = S_DONE;
            end
            S_F0:
            begin
                mem_ra16   = {4'd0, pc_reg};
                state_next = S_F1;
            end
            S_F1:
            begin
                mem_ra16       = {4'd0, pc_reg + 12'd1};
                op_next[15:8]  = mem_q_reg;
                state_next     = S_F2;
            end
            S_F2:
            begin
                op_next[7:0] = mem_q_reg;
                v_ra         = (op_reg[15:12] == 4'hB) ? 4'd0 : op_reg[11:8];
                state_next   = S_RY;
            end
            S_RY:
            begin
                va_next    = vq_reg;
                v_ra       = y;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                pc_next    = pc2;
                state_next = S_DONE;
                unique case (op_reg[15:12])
                    4'h0:
                    begin
                        if (op_reg == OPC_RET)
                        begin
                            pc_next = pc_reg;
                            if (depth_reg == '0)
                            begin
                                st_next = ST_UNDER;
                            end
                            else
                            begin
                                state_next = S_RET;
                            end
                        end
                    end
                    4'h1: pc_next = nnn;
                    4'h2:
                    begin
                        if (depth_reg >= DW'(STACK_ENTRIES))
                        begin
                            st_next = ST_OVER;
                            pc_next = pc_reg;
                        end
                        else
                        begin
                            stk_we     = 1'b1;
                            depth_next = depth_reg + 1'b1;
                            pc_next    = nnn;
                        end
                    end
                    4'h3: pc_next = (va_reg == nn) ? pc4 : pc2;
                    4'h4: pc_next = (va_reg != nn) ? pc4 : pc2;
                    4'h5, 4'h9:
                    begin
                        if (n != 4'd0)
                        begin
                            st_next = ST_UNK;
                            pc_next = pc_reg;
                        end
                        else if ((va_reg == vq_reg) ^ op_reg[15])
                        begin
                            pc_next = pc4;
                        end
                    end
                    4'h6:
                    begin
                        v_we = 1'b1;
                        v_wd = nn;
                    end
                    4'h7:
                    begin
                        v_we = 1'b1;
                        v_wd = va_reg + nn;
                    end
                    4'h8:
                    begin
                        v_we = 1'b1;
                        unique case (n)
                            4'h0: v_wd = vq_reg;
                            4'h1: v_wd = va_reg | vq_reg;
                            4'h2: v_wd = va_reg & vq_reg;
                            4'h3: v_wd = va_reg ^ vq_reg;
                            4'h4:
                            begin
                                v_wd      = sum9[7:0];
                                flag_next = sum9[8];
                            end
                            4'h5:
                            begin
                                v_wd      = va_reg - vq_reg;
                                flag_next = vq_reg > va_reg;
                            end
                            4'h6:
                            begin
                                v_wd      = {1'b0, vq_reg[7:1]};
                                flag_next = vq_reg[0];
                            end
                            4'h7:
                            begin
                                v_wd      = vq_reg - va_reg;
                                flag_next = va_reg > vq_reg;
                            end
                            4'hE:
                            begin
                                v_wd      = {vq_reg[6:0], 1'b0};
                                flag_next = vq_reg[7];
                            end
                            default:
                            begin
                                v_we    = 1'b0;
                                st_next = ST_UNK;
                                pc_next = pc_reg;
                            end
                        endcase
                        if (v_we && (n[2] || n[3]) && (x != 4'hF))
                        begin
                            state_next = S_FLAG;
                        end
                    end
                    4'hA: idx_next = {4'd0, nnn};
                    4'hB: pc_next = nnn + {4'd0, va_reg};
                    4'hC:
                    begin
                        v_we = 1'b1;
                        v_wd = item_reg.random_byte & nn;
                    end
                    4'hD: pc_next = pc2;
                    4'hE:
                    begin
                        pc_next = pc_reg;
                        if (nn != 8'h9E && nn != 8'hA1)
                        begin
                            st_next = ST_UNK;
                        end
                    end
                    4'hF:
                    begin
                        unique case (nn)
                            8'h07:
                            begin
                                v_we = 1'b1;
                                v_wd = dly_reg;
                            end
                            8'h0A, 8'h29: pc_next = pc2;
                            8'h15: dly_next = va_reg;
                            8'h18: snd_next = va_reg;
                            8'h1E: idx_next = idx_reg + {8'd0, va_reg};
                            8'h33:
                            begin
                                cnt_next   = 2'd0;
                                state_next = S_BCD;
                            end
                            8'h55:
                            begin
                                i_next     = 4'd0;
                                state_next = S_STR;
                            end
                            8'h65:
                            begin
                                i_next     = 4'd0;
                                state_next = S_LDR;
                            end
                            default:
                            begin
                                st_next = ST_UNK;
                                pc_next = pc_reg;
                            end
                        endcase
                    end
                    default: st_next = ST_UNK;
                endcase
            end
            S_FLAG:
            begin
                v_we       = 1'b1;
                v_wa       = 4'hF;
                v_wd       = {7'd0, flag_reg};
                state_next = S_DONE;
            end
            S_RET:
            begin
                pc_next    = stack_q_reg;
                depth_next = depth_m1;
                state_next = S_DONE;
            end
            S_BCD:
            begin
                mem_we   = 1'b1;
                mem_wa16 = idx_reg + {14'd0, cnt_reg};
                mem_wd   = bcd_digit(va_reg, cnt_reg);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2)
                begin
                    state_next = S_DONE;
                end
            end
            S_STR:
            begin
                v_ra       = i_reg;
                state_next = S_STW;
            end
            S_STW:
            begin
                mem_we     = 1'b1;
                mem_wa16   = idx_reg;
                mem_wd     = vq_reg;
                idx_next   = idx_reg + 16'd1;
                i_next     = i_reg + 4'd1;
                state_next = (i_reg == x) ? S_DONE : S_STR;
            end
            S_LDR:
            begin
                mem_ra16   = idx_reg;
                state_next = S_LDW;
            end
            S_LDW:
            begin
                v_we       = 1'b1;
                v_wa       = i_reg;
                v_wd       = mem_q_reg;
                idx_next   = idx_reg + 16'd1;
                i_next     = i_reg + 4'd1;
                state_next = (i_reg == x) ? S_DONE : S_LDR;
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.read_data           = rd_reg;
                    res_next.program_counter_out = pc_reg;
                    res_next.index_out           = idx_reg;
                    res_next.opcode_out          = op_reg;
                    res_next.status              = st_reg;
                    res_next.delay_out           = dly_reg;
                    res_next.sound_out           = snd_reg;
                    res_valid_next               = 1'b1;
                    state_next                   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cfg_we)
        begin
            pc_next = cfg_pc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wd;
        end
        mem_q_reg <= mem[mem_raddr];
        if (v_we)
        begin
            vfile[v_wa] <= v_wd;
        end
        vq_reg <= vvalid_reg[v_ra] ? vfile[v_ra] : 8'd0;
        if (stk_we)
        begin
            stack[depth_reg[SW-1:0]] <= pc2;
        end
        stack_q_reg <= stack[depth_m1[SW-1:0]];
        op_reg   <= op_next;
        item_reg <= item_next;
        rd_reg   <= rd_next;
        st_reg   <= st_next;
        va_reg   <= va_next;
        flag_reg <= flag_next;
        i_reg    <= i_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= PC_RESET;
            idx_reg       <= 16'd0;
            dly_reg       <= 8'd0;
            snd_reg       <= 8'd0;
            depth_reg     <= '0;
            vvalid_reg    <= 16'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            idx_reg       <= idx_next;
            dly_reg       <= dly_next;
            snd_reg       <= snd_next;
            depth_reg     <= depth_next;
            res_valid_reg <= res_valid_next;
            if (v_we)
            begin
                vvalid_reg[v_wa] <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/chip8_instruction_executor_core.sv =====
// Steps (single memory port, single register file read port): a memory write
// goes to S_DONE; a read adds S_MRD or S_RREG, then S_CAP; execute runs S_F0
// to S_EXEC, then S_FLAG, S_RET, S_BCD per digit or S_STR/S_LDR per register.
// Throughput: one request at a time in the executor, a 2-deep queue ahead.
// Reset (rst_n, async low): registers, timers, index and stack depth clear,
// pc loads 512; memory and return stack are not cleared.
`default_nettype none
module chip8_instruction_executor_core #(
    parameter int unsigned MEMORY_BYTES  = c8ie_pkg::MEM_BYTES_DEF,
    parameter int unsigned STACK_ENTRIES = c8ie_pkg::STACK_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[1:0], address[13:2], write_data[21:14], random_byte[29:22]
    input  wire logic [31:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // read_data[7:0], program_counter_out[19:8], index_out[35:20],
    // opcode_out[51:36], status[53:52], delay_out[61:54], sound_out[69:62]
    output logic [71:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);
    import c8ie_pkg::*;

    c8ie_item_t   q_item;
    logic         q_valid;
    logic         q_pop;
    c8ie_result_t res;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {2'b00, res};

    c8ie_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (c8ie_item_t'(s_axis_tdata[29:0])),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    c8ie_exec #(
        .MEMORY_BYTES  (MEMORY_BYTES),
        .STACK_ENTRIES (STACK_ENTRIES)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_we    (cfg_valid),
        .cfg_pc    (cfg_data),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );
endmodule
`default_nettype wire

// ===== rtl/c8ie_checker.sv =====
`default_nettype none
module c8ie_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata
);
    import c8ie_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    a_fault_op: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[53:52] != ST_OK) |-> m_axis_tdata[51:36] != 16'd0)
        else $error("fault reported without an instruction");

    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[53:52] == ST_OVER) |-> m_axis_tdata[51:48] == 4'h2)
        else $error("overflow on a non-call");

    a_under: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[53:52] == ST_UNDER) |-> m_axis_tdata[51:36] == OPC_RET)
        else $error("underflow on a non-return");

    a_rd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[51:36] != 16'd0) |-> m_axis_tdata[7:0] == 8'd0)
        else $error("read data on an execute result");
endmodule

bind chip8_instruction_executor_core c8ie_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
